FILE: rtl/dthm_pkg.sv
// ----------------------------------------------------------------------------
// dthm_pkg
// Shared constants and types of the depth heat-map colorizer.
// ----------------------------------------------------------------------------
package dthm_pkg;

	// Width of the depth samples that take part in the arithmetic.
	localparam int DEPTH_BITS = 16;
	// Upper end of the normalized range.
	localparam int NORM_TOP   = 2013;

	// Quotient bits: the normalized value never exceeds NORM_TOP.
	localparam int QBITS      = $clog2(NORM_TOP + 1);
	// Width of the scaled numerator (offset times NORM_TOP).
	localparam int NUM_W      = DEPTH_BITS + QBITS;
	// Iteration counter width.
	localparam int CNT_W      = $clog2(QBITS + 1);
	// Square and cube widths.
	localparam int SQ_W       = 2 * QBITS;
	localparam int CUBE_W     = 3 * QBITS;
	// Width of nine times the cube, padded so the band and position bits always exist.
	localparam int SC_W       = CUBE_W + 12;
	// Gamma curve: floor(9 * n^3 / 2^GAMMA_SHIFT).
	localparam int GAMMA_SHIFT = 23;
	// Number of color ramps; any higher band is black.
	localparam int NUM_BANDS  = 6;

	localparam logic [7:0] CH_FULL = 8'hff;
	localparam logic [7:0] CH_NONE = 8'h00;

	// Request codes.
	localparam logic REQ_MEASURE  = 1'b0;
	localparam logic REQ_COLORIZE = 1'b1;

	// Sequencer states, one-hot.
	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_MUL  = 7'b0000010,
		S_DIV  = 7'b0000100,
		S_RND  = 7'b0001000,
		S_SQR  = 7'b0010000,
		S_CUB  = 7'b0100000,
		S_OUT  = 7'b1000000
	} state_t;

endpackage

FILE: rtl/depth_to_color_heatmap.sv
// ----------------------------------------------------------------------------
// depth_to_color_heatmap
// Turns depth pixels into BGR heat-map colors using a serial divider.
// ----------------------------------------------------------------------------
// Each frame is sent twice on the request channel (req_valid / req_stall).
// A measure item (req_type 0) updates the running minimum and maximum depth;
// first_pixel restarts both at the sample. It gives no result and leaves the
// block idle. A colorize item (req_type 1) is clamped to the measured range,
// scaled by NORM_TOP, divided by the depth span in a restoring divider that
// retires one quotient bit per cycle, rounded half to even, then cubed with
// two registered multiplies and mapped to one of six color ramps or to black.
// A colorize item steps through S_MUL, S_DIV, S_RND, S_SQR, S_CUB and S_OUT;
// its result then appears on blue, green, red with res_valid. req_stall is
// high while an item is in work. The result sits in an output register, so
// a new item may be accepted while res_stall holds the previous result; a
// finished colorize item waits in its last step until that register is free.
// Reset clears the minimum and maximum to zero and empties the output.
// ----------------------------------------------------------------------------
module depth_to_color_heatmap
	import dthm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic        req_type,
	input  logic [15:0] depth_value,
	input  logic        first_pixel,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [7:0]  blue,
	output logic [7:0]  green,
	output logic [7:0]  red
);

	state_t                state_q;
	logic [DEPTH_BITS-1:0] lo_q;
	logic [DEPTH_BITS-1:0] hi_q;
	logic [DEPTH_BITS-1:0] off_q;
	logic [DEPTH_BITS-1:0] span_q;
	logic                  zero_q;
	logic [DEPTH_BITS-1:0] rem_q;
	logic [QBITS-1:0]      qsh_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [QBITS-1:0]      n_q;
	logic [SQ_W-1:0]       sq_q;
	logic [CUBE_W-1:0]     cube_q;
	logic                  res_valid_q;
	logic [7:0]            blue_q;
	logic [7:0]            green_q;
	logic [7:0]            red_q;

	logic                  req_acc;
	logic                  out_free;
	logic [DEPTH_BITS-1:0] d;
	logic [DEPTH_BITS-1:0] d_clamp;
	logic [NUM_W-1:0]      num;
	logic [DEPTH_BITS:0]   trial;
	logic [DEPTH_BITS:0]   trial_diff;
	logic                  q_bit;
	logic [DEPTH_BITS:0]   rem2;
	logic                  round_up;
	logic [SC_W-1:0]       scaled;
	logic [SC_W-1:0]       gamma;
	logic [SC_W-1:0]       band;
	logic [7:0]            lb;
	logic [7:0]            c_b;
	logic [7:0]            c_g;
	logic [7:0]            c_r;

	assign req_stall = (state_q != S_IDLE);
	assign req_acc   = req_valid && !req_stall;
	assign out_free  = !res_valid_q || !res_stall;

	assign d = depth_value[DEPTH_BITS-1:0];

	always_comb begin
		d_clamp = d;
		if (d < lo_q) begin
			d_clamp = lo_q;
		end
		if (d > hi_q) begin
			d_clamp = hi_q;
		end
	end

	assign num = NUM_W'(off_q) * NUM_W'(NORM_TOP);

	// One restoring division step: bring down the next numerator bit.
	assign trial      = {rem_q, qsh_q[QBITS-1]};
	assign trial_diff = trial - {1'b0, span_q};
	assign q_bit      = (trial >= {1'b0, span_q});

	// Round half to even on the final remainder.
	assign rem2     = {rem_q, 1'b0};
	assign round_up = (rem2 > {1'b0, span_q}) || ((rem2 == {1'b0, span_q}) && qsh_q[0]);

	assign scaled = SC_W'({cube_q, 3'b000}) + SC_W'(cube_q);
	assign gamma  = scaled >> GAMMA_SHIFT;
	assign band   = gamma >> 8;
	assign lb     = gamma[7:0];

	always_comb begin
		c_b = CH_NONE;
		c_g = CH_NONE;
		c_r = CH_NONE;
		if (band < SC_W'(NUM_BANDS)) begin
			case (band[2:0])
				3'd0: begin
					c_b = CH_FULL - lb;
					c_g = CH_FULL - lb;
					c_r = CH_FULL;
				end
				3'd1: begin
					c_g = lb;
					c_r = CH_FULL;
				end
				3'd2: begin
					c_g = CH_FULL;
					c_r = CH_FULL - lb;
				end
				3'd3: begin
					c_b = lb;
					c_g = CH_FULL;
				end
				3'd4: begin
					c_b = CH_FULL;
					c_g = CH_FULL - lb;
				end
				3'd5: begin
					c_b = CH_FULL - lb;
				end
				default: begin
					c_b = CH_NONE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			lo_q        <= '0;
			hi_q        <= '0;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			// A new result loads the output register; otherwise a taken result empties it.
			if (state_q == S_OUT && out_free) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_acc) begin
						if (req_type == REQ_MEASURE) begin
							if (first_pixel) begin
								lo_q <= d;
								hi_q <= d;
							end else begin
								if (d < lo_q) begin
									lo_q <= d;
								end
								if (d > hi_q) begin
									hi_q <= d;
								end
							end
						end else begin
							state_q <= S_MUL;
						end
					end
				end
				S_MUL: begin
					cnt_q   <= CNT_W'(QBITS - 1);
					state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= S_RND;
					end
				end
				S_RND: begin
					state_q <= S_SQR;
				end
				S_SQR: begin
					state_q <= S_CUB;
				end
				S_CUB: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers, no reset needed.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req_acc) begin
			off_q  <= d_clamp - lo_q;
			span_q <= hi_q - lo_q;
			zero_q <= (hi_q <= lo_q);
		end
		if (state_q == S_MUL) begin
			// The quotient fits in QBITS, so the upper part is below the span.
			rem_q <= num[NUM_W-1:QBITS];
			qsh_q <= num[QBITS-1:0];
		end
		if (state_q == S_DIV) begin
			rem_q <= q_bit ? trial_diff[DEPTH_BITS-1:0] : trial[DEPTH_BITS-1:0];
			qsh_q <= {qsh_q[QBITS-2:0], q_bit};
		end
		if (state_q == S_RND) begin
			n_q <= zero_q ? '0 : qsh_q + QBITS'(round_up);
		end
		if (state_q == S_SQR) begin
			sq_q <= SQ_W'(n_q) * SQ_W'(n_q);
		end
		if (state_q == S_CUB) begin
			cube_q <= CUBE_W'(sq_q) * CUBE_W'(n_q);
		end
		if (state_q == S_OUT && out_free) begin
			blue_q  <= c_b;
			green_q <= c_g;
			red_q   <= c_r;
		end
	end

	assign res_valid = res_valid_q;
	assign blue      = blue_q;
	assign green     = green_q;
	assign red       = red_q;

endmodule
